>>> rtl/mmlp_pkg.sv
// Shared constants and request / register codes for the minimax label propagation block.
`default_nettype none
package mmlp_pkg;
  localparam int NODES    = 1024;
  localparam int NODE_W   = 10;
  localparam int CNT_W    = 11;
  localparam int EDGES    = 8192;
  localparam int EDGE_W   = 13;
  localparam int COL_W    = 14;
  localparam int DIST_W   = 32;
  localparam int LABEL_W  = 8;
  localparam int HOP_W    = 16;
  localparam int IN_DW    = 120;
  localparam int OUT_DW   = 88;

  typedef enum logic [2:0] {
    REQ_LOAD_NODE = 3'd0,
    REQ_PUSH_SEED = 3'd1,
    REQ_LOAD_COL  = 3'd2,
    REQ_LOAD_EDGE = 3'd3,
    REQ_RUN       = 3'd4,
    REQ_READ_NODE = 3'd5
  } req_t;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_STOP_COUNT = 2'd1;
  localparam logic [1:0] CFG_EARLY_STOP = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [CNT_W-1:0] NODES_CNT = CNT_W'(NODES);
endpackage
`default_nettype wire

>>> rtl/minimax_label_propagation.sv
// Minimax label propagation engine: graph, node and queue memories with a run sequencer.
// Usage:
//  Input channel in_*: tuser carries the request type, tdata the load/seed/read fields.
//  Load node, load column start and load edge are single memory writes, one per cycle.
//  Push seed reads the queued flag, then enqueues.
//  Read node returns one result with tuser = 1.
//  Run clears the hop memory, then pops nodes: each popped node passes S_POP, S_POP2,
//  S_NODE, S_EDGE and S_FIN; each edge passes S_EDGE and S_EDGE2, plus S_NB if its
//  neighbour is in the node range; edge and node memory reads are registered. It
//  returns one status result with tuser = 0, then clears the queued/visited flags.
//  Result channel out_*: one output register; a new item is taken while a result
//  waits, but a read or run holds in its last step until the register is free.
//  Config channel cfg_*: always ready; write only while the block is idle.
//  Reset (rst_n low, synchronous) clears control state and then sweeps the hop and
//  flag memories before in_tready rises.
`default_nettype none
module minimax_label_propagation
  import mmlp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // node_index, node_label, node_distance, column_start, edge_index,
  // edge_neighbor, edge_weight
  input  wire logic [IN_DW-1:0]  in_tdata,
  // req_type
  input  wire logic [2:0]        in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // out_label, out_distance, out_hops, out_levels, out_visited, out_stopped_early
  output logic [OUT_DW-1:0]      out_tdata,
  // result_kind
  output logic                   out_tuser,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CNT_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SEED, S_SEED2, S_RD, S_RD2, S_HCLR, S_POP, S_POP2,
    S_NODE, S_EDGE, S_EDGE2, S_NB, S_FIN, S_DONE, S_FCLR
  } state_t;

  state_t state_r;

  logic [NODE_W-1:0]  f_idx;
  logic [LABEL_W-1:0] f_label;
  logic [DIST_W-1:0]  f_dist;
  logic [COL_W-1:0]   f_col;
  logic [EDGE_W-1:0]  f_eidx;
  logic [NODE_W-1:0]  f_nbr;
  logic [DIST_W-1:0]  f_wgt;
  req_t               f_req;

  assign f_idx   = in_tdata[9:0];
  assign f_label = in_tdata[17:10];
  assign f_dist  = in_tdata[49:18];
  assign f_col   = in_tdata[63:50];
  assign f_eidx  = in_tdata[76:64];
  assign f_nbr   = in_tdata[86:77];
  assign f_wgt   = in_tdata[118:87];
  assign f_req   = req_t'(in_tuser);

  logic [CNT_W-1:0]  node_count_r, stop_count_r;
  logic              early_en_r;

  logic [NODE_W-1:0] idx_r, cnt_r, head_r, mark_r, i_r, j_r;
  logic [CNT_W-1:0]  fill_r, visited_r;
  logic [HOP_W-1:0]  level_r;
  logic [COL_W-1:0]  t_r, end_r;
  logic [DIST_W-1:0] dist_i_r, val_r;
  logic [LABEL_W-1:0] lab_i_r;
  logic              vis_i_r, early_r;
  logic              out_valid_r, out_kind_r;
  logic [OUT_DW-1:0] out_data_r;

  // memories
  logic [LABEL_W-1:0] lab_mem  [NODES];
  logic [DIST_W-1:0]  dist_mem [NODES];
  logic [HOP_W-1:0]   hop_mem  [NODES];
  logic [1:0]         flag_mem [NODES];  // [1] queued, [0] visited
  logic [NODE_W-1:0]  queue_mem[NODES];
  logic [COL_W-1:0]   col_mem  [NODES];
  logic [NODE_W-1:0]  nbr_mem  [EDGES];
  logic [DIST_W-1:0]  wgt_mem  [EDGES];

  logic [LABEL_W-1:0] lab_rd;
  logic [DIST_W-1:0]  dist_rd, wgt_rd;
  logic [HOP_W-1:0]   hop_rd;
  logic [1:0]         flag_rd;
  logic [NODE_W-1:0]  q_rd, nbr_rd;
  logic [COL_W-1:0]   col_rd0, col_rd1;

  logic               node_we, hop_we, flag_we, q_we, col_we, edge_we;
  logic [NODE_W-1:0]  node_wa, hop_wa, flag_wa, q_wa, node_ra, flag_ra;
  logic [LABEL_W-1:0] lab_wd;
  logic [DIST_W-1:0]  dist_wd;
  logic [HOP_W-1:0]   hop_wd;
  logic [1:0]         flag_wd;
  logic [NODE_W-1:0]  q_wd, col_ra1;

  logic               accept, out_free, upd, enq, in_range_j;
  logic [NODE_W-1:0]  tail;
  logic [DIST_W-1:0]  val;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign tail       = head_r + fill_r[NODE_W-1:0];
  assign val        = (dist_i_r >= wgt_rd) ? dist_i_r : wgt_rd;
  assign in_range_j = {1'b0, nbr_rd} < node_count_r;
  assign upd        = val_r < dist_rd;
  assign enq        = upd && !flag_rd[1] && !fill_r[CNT_W-1];
  assign col_ra1    = q_rd + NODE_W'(1);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  always_comb begin
    node_we = 1'b0; node_wa = idx_r; lab_wd = lab_i_r; dist_wd = val_r;
    hop_we  = 1'b0; hop_wa  = cnt_r; hop_wd = '0;
    flag_we = 1'b0; flag_wa = cnt_r; flag_wd = '0;
    q_we    = 1'b0; q_wa    = tail;  q_wd   = j_r;
    col_we  = 1'b0; edge_we = 1'b0;
    node_ra = idx_r; flag_ra = idx_r;
    unique case (state_r)
      S_CLR: begin
        hop_we = 1'b1; flag_we = 1'b1;
      end
      S_IDLE: begin
        node_wa = f_idx; lab_wd = f_label; dist_wd = f_dist;
        node_we = accept && (f_req == REQ_LOAD_NODE);
        col_we  = accept && (f_req == REQ_LOAD_COL);
        edge_we = accept && (f_req == REQ_LOAD_EDGE);
      end
      S_SEED2: begin
        flag_wa = idx_r; flag_wd = 2'b11; q_wd = idx_r;
        flag_we = ({1'b0, idx_r} < node_count_r) && !flag_rd[1] && !fill_r[CNT_W-1];
        q_we    = flag_we;
      end
      S_HCLR: hop_we = 1'b1;
      S_POP2: begin
        node_ra = q_rd; flag_ra = q_rd;
      end
      S_EDGE2: begin
        node_ra = nbr_rd; flag_ra = nbr_rd;
      end
      S_NB: begin
        node_wa = j_r; node_we = upd;
        hop_wa = j_r; hop_wd = level_r; hop_we = upd;
        flag_wa = j_r; flag_wd = 2'b11; flag_we = enq;
        q_we = enq;
      end
      S_FIN: begin
        flag_wa = i_r; flag_wd = {1'b0, vis_i_r}; flag_we = 1'b1;
      end
      S_FCLR: flag_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      lab_mem[node_wa]  <= lab_wd;
      dist_mem[node_wa] <= dist_wd;
    end
    lab_rd  <= lab_mem[node_ra];
    dist_rd <= dist_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (hop_we) hop_mem[hop_wa] <= hop_wd;
    hop_rd <= hop_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_wa] <= flag_wd;
    flag_rd <= flag_mem[flag_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_wa] <= q_wd;
    q_rd <= queue_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (col_we) col_mem[f_idx] <= f_col;
    col_rd0 <= col_mem[q_rd];
    col_rd1 <= col_mem[col_ra1];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      nbr_mem[f_eidx] <= f_nbr;
      wgt_mem[f_eidx] <= f_wgt;
    end
    nbr_rd <= nbr_mem[t_r[EDGE_W-1:0]];
    wgt_rd <= wgt_mem[t_r[EDGE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cnt_r        <= '0;
      node_count_r <= NODES_CNT;
      stop_count_r <= NODES_CNT;
      early_en_r   <= 1'b0;
      head_r       <= '0;
      fill_r       <= '0;
      mark_r       <= '0;
      level_r      <= '0;
      visited_r    <= '0;
      early_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: node_count_r <= cfg_data;
          CFG_STOP_COUNT: stop_count_r <= cfg_data;
          CFG_EARLY_STOP: early_en_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLR, S_FCLR: begin
          cnt_r <= cnt_r + NODE_W'(1);
          if (cnt_r == NODE_W'(NODES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          idx_r <= f_idx;
          cnt_r <= '0;
          if (accept) begin
            priority case (f_req)
              REQ_PUSH_SEED: state_r <= S_SEED;
              REQ_READ_NODE: state_r <= S_RD;
              REQ_RUN:       state_r <= S_HCLR;
              default:       state_r <= S_IDLE;
            endcase
          end
        end
        S_SEED: state_r <= S_SEED2;
        S_SEED2: begin
          if (flag_we) begin
            fill_r <= fill_r + CNT_W'(1);
            if (!flag_rd[0]) visited_r <= visited_r + CNT_W'(1);
          end
          state_r <= S_IDLE;
        end
        S_RD: state_r <= S_RD2;
        S_RD2: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_READ;
            out_data_r  <= {32'd0, hop_rd, dist_rd, lab_rd};
            state_r     <= S_IDLE;
          end
        end
        S_HCLR: begin
          cnt_r <= cnt_r + NODE_W'(1);
          if (cnt_r == NODE_W'(NODES - 1)) begin
            level_r <= '0;
            mark_r  <= tail;
            early_r <= 1'b0;
            state_r <= (fill_r == '0) ? S_DONE : S_POP;
          end
        end
        S_POP: state_r <= S_POP2;
        S_POP2: begin
          i_r     <= q_rd;
          head_r  <= head_r + NODE_W'(1);
          fill_r  <= fill_r - CNT_W'(1);
          state_r <= S_NODE;
        end
        S_NODE: begin
          dist_i_r <= dist_rd;
          lab_i_r  <= lab_rd;
          vis_i_r  <= flag_rd[0];
          t_r      <= col_rd0;
          if (({1'b0, i_r} >= node_count_r) || (i_r == NODE_W'(NODES - 1)))
            end_r <= '0;
          else
            end_r <= col_rd1;
          state_r <= S_EDGE;
        end
        S_EDGE: begin
          if ((t_r < end_r) && !t_r[COL_W-1]) state_r <= S_EDGE2;
          else state_r <= S_FIN;
        end
        S_EDGE2: begin
          j_r   <= nbr_rd;
          val_r <= val;
          if (in_range_j) begin
            state_r <= S_NB;
          end else begin
            t_r     <= t_r + COL_W'(1);
            state_r <= S_EDGE;
          end
        end
        S_NB: begin
          if (enq) begin
            fill_r <= fill_r + CNT_W'(1);
            if (!flag_rd[0]) visited_r <= visited_r + CNT_W'(1);
          end
          t_r     <= t_r + COL_W'(1);
          state_r <= S_EDGE;
        end
        S_FIN: begin
          if (head_r == mark_r) begin
            if (level_r != '1) level_r <= level_r + HOP_W'(1);
            mark_r <= tail;
          end
          if (early_en_r && (visited_r >= stop_count_r)) begin
            early_r <= 1'b1;
            state_r <= S_DONE;
          end else if (fill_r == '0) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_POP;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_STATUS;
            out_data_r  <= {4'd0, early_r, visited_r, level_r, 56'd0};
            head_r      <= '0;
            fill_r      <= '0;
            mark_r      <= '0;
            level_r     <= '0;
            visited_r   <= '0;
            cnt_r       <= '0;
            state_r     <= S_FCLR;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/mmlp_checker.sv
// Port-level checks for minimax_label_propagation, bound to the top level.
`default_nettype none
module mmlp_assertions
  import mmlp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic              out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_STATUS) |-> out_tdata[55:0] == '0)
    else $error("status transaction carries node data");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_READ) |-> out_tdata[87:56] == '0)
    else $error("read transaction carries run status");

  a_visited_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[82:72] <= NODES_CNT)
    else $error("visited count beyond node capacity");

endmodule

bind minimax_label_propagation mmlp_assertions u_mmlp_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
